/* hdl/rgbe_scanline_rle_decoder_top_defines.svh */
// Assertion macros shared by the RGBE scanline decoder modules.
`ifndef RGBE_SCANLINE_RLE_DECODER_TOP_DEFINES_SVH
`define RGBE_SCANLINE_RLE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RGBE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rgbe_rle: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RGBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rgbe_rle: next-cycle check failed");

`endif

/* hdl/rgbe_rle_pkg.sv */
// Types, codes and helpers shared by the RGBE scanline decoder.
package rgbe_rle_pkg;

    localparam int DIM_DEFAULT = 8192;
    localparam int REG_W       = 14;
    localparam int ROW_W       = 13;
    localparam int COL_W       = 13;
    localparam int CH_W        = 2;
    localparam int BYTE_W      = 8;
    localparam int REP_W       = 7;
    localparam int ERR_W       = 3;
    localparam int NRES        = 3;
    localparam int CNT_W       = 2;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [BYTE_W-1:0] RLE_MARK = 8'h02;
    localparam logic [BYTE_W-1:0] RUN_BIAS = 8'd128;
    localparam logic [CH_W-1:0]   CH_LAST  = 2'd3;

    typedef enum logic [3:0] {
        PH_START,
        PH_SECOND,
        PH_RLE_HI,
        PH_RLE_LO,
        PH_CODE,
        PH_RUNVAL,
        PH_LIT,
        PH_FLAT,
        PH_DONE,
        PH_HALT
    } t_phase;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_TRUNC    = 3'd1,
        ERR_WIDTH    = 3'd2,
        ERR_RUN_OVR  = 3'd3,
        ERR_ZERO_LIT = 3'd4,
        ERR_LIT_OVR  = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        REG_SCAN_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_FLIP         = 2'd2
    } t_reg_idx;

    // Effective (clamped) image geometry seen by the decoder.
    typedef struct packed {
        logic [REG_W-1:0] width;
        logic [REG_W-1:0] height;
        logic             flip;
    } t_cfg;

    typedef struct packed {
        logic              is_write;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [CH_W-1:0]   channel;
        logic [BYTE_W-1:0] value;
        logic [REP_W-1:0]  rep;
        t_err              err;
        logic              image_done;
        logic              last;
    } t_result;

    // Results of one byte, in delivery order; cnt of zero means nothing to load.
    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        t_result [NRES-1:0]   res;
    } t_batch;

    function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v,
                                                   input int unsigned lim);
        logic [REG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = REG_W'(1);
        end else if (int'(v) > int'(lim)) begin
            r = REG_W'(lim);
        end
        return r;
    endfunction

endpackage

/* hdl/rgbe_rle_cfg.sv */
// APB register block holding scan width, image height and flip control.
module rgbe_rle_cfg #(
    parameter int MAX_DIMENSION = rgbe_rle_pkg::DIM_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgbe_rle_pkg::PADDR_W-1:0] paddr,
    input  logic [rgbe_rle_pkg::PDATA_W-1:0] pwdata,
    output logic [rgbe_rle_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output rgbe_rle_pkg::t_cfg               o_cfg
);
    import rgbe_rle_pkg::*;

    logic [REG_W-1:0] r_scan_width;
    logic [REG_W-1:0] r_image_height;
    logic             r_flip;
    logic [REG_W-1:0] r_w_eff;
    logic [REG_W-1:0] r_h_eff;
    logic             wr_en;
    t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_width   <= REG_W'(1);
            r_image_height <= REG_W'(1);
            r_flip         <= 1'b0;
            r_w_eff        <= REG_W'(1);
            r_h_eff        <= REG_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_SCAN_WIDTH: begin
                    r_scan_width <= pwdata[REG_W-1:0];
                    r_w_eff      <= clamp_dim(pwdata[REG_W-1:0], MAX_DIMENSION);
                end
                REG_IMAGE_HEIGHT: begin
                    r_image_height <= pwdata[REG_W-1:0];
                    r_h_eff        <= clamp_dim(pwdata[REG_W-1:0], MAX_DIMENSION);
                end
                REG_FLIP: begin
                    r_flip <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SCAN_WIDTH:   prdata = PDATA_W'(r_scan_width);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(r_image_height);
            REG_FLIP:         prdata = PDATA_W'(r_flip);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.width  = r_w_eff;
    assign o_cfg.height = r_h_eff;
    assign o_cfg.flip   = r_flip;

endmodule

/* hdl/rgbe_rle_core.sv */
// Input byte register, scanline/run state machine and per-byte result builder.
`include "rgbe_scanline_rle_decoder_top_defines.svh"
module rgbe_rle_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rgbe_rle_pkg::t_cfg              i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rgbe_rle_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                            i_final_byte,
    input  logic                            i_load_ok,
    output rgbe_rle_pkg::t_batch            o_batch
);
    import rgbe_rle_pkg::*;

    // Input register
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_byte;
    logic              r_fin;

    // Decode state
    t_phase            r_phase,   n_phase;
    logic [CH_W-1:0]   r_ch,      n_ch;
    logic [REG_W-1:0]  r_col,     n_col;
    logic [REG_W-1:0]  r_row,     n_row;
    logic [BYTE_W-1:0] r_run,     n_run;
    logic [BYTE_W-1:0] r_held,    n_held;
    t_err              r_err,     n_err;

    logic              proc;
    logic              active;
    t_err              prim_err;
    logic              trunc;
    logic              has_stat;
    logic [REG_W:0]    w_ext;
    logic [REG_W-1:0]  row_inc;
    t_phase            end_phase;
    logic [REG_W:0]    adv_col;
    logic [BYTE_W-1:0] adv_run;
    logic [REG_W:0]    run_sum;
    logic [REG_W:0]    lit_sum;
    logic [REG_W:0]    flat_col;
    logic [CH_W-1:0]   ch_inc;
    logic [REG_W-1:0]  y_sat;
    logic [REG_W-1:0]  dest_row;
    logic [CNT_W-1:0]  nw;
    t_result           wr0, wr1, stat;

    assign proc       = r_in_vld && i_load_ok;
    assign o_in_stall = r_in_vld && !i_load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_byte <= i_data_byte;
            r_fin  <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_ch    <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_run   <= '0;
            r_held  <= '0;
            r_err   <= ERR_NONE;
        end else if (proc) begin
            r_phase <= n_phase;
            r_ch    <= n_ch;
            r_col   <= n_col;
            r_row   <= n_row;
            r_run   <= n_run;
            r_held  <= n_held;
            r_err   <= n_err;
        end
    end

    assign active    = (r_phase != PH_DONE) && (r_phase != PH_HALT) && (r_err == ERR_NONE);
    assign w_ext     = {1'b0, i_cfg.width};
    assign row_inc   = r_row + REG_W'(1);
    assign end_phase = (row_inc >= i_cfg.height) ? PH_DONE : PH_START;
    assign run_sum   = {1'b0, r_col} + (REG_W + 1)'(r_byte[BYTE_W-2:0]);
    assign lit_sum   = {1'b0, r_col} + (REG_W + 1)'(r_byte);
    assign flat_col  = {1'b0, r_col} + (REG_W + 1)'(1);
    assign ch_inc    = r_ch + CH_W'(1);
    assign adv_col   = (r_phase == PH_RUNVAL) ? ({1'b0, r_col} + (REG_W + 1)'(r_run))
                                              : flat_col;
    assign adv_run   = (r_phase == PH_LIT && r_run != '0) ? (r_run - BYTE_W'(1)) : '0;

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_ch     = r_ch;
        n_col    = r_col;
        n_row    = r_row;
        n_run    = r_run;
        n_held   = r_held;
        n_err    = r_err;
        prim_err = ERR_NONE;
        trunc    = 1'b0;
        if (active) begin
            case (r_phase)
                PH_START: begin
                    n_held  = r_byte;
                    n_phase = PH_SECOND;
                end
                PH_SECOND: begin
                    if (r_held == RLE_MARK && r_byte == RLE_MARK) begin
                        n_phase = PH_RLE_HI;
                    end else begin
                        // two flat writes leave this byte together: channels 0 and 1 of column 0
                        n_col   = '0;
                        n_ch    = CH_W'(2);
                        n_phase = PH_FLAT;
                    end
                end
                PH_RLE_HI: begin
                    n_held  = r_byte;
                    n_phase = PH_RLE_LO;
                end
                PH_RLE_LO: begin
                    if ({r_held, r_byte} != (2 * BYTE_W)'(i_cfg.width)) begin
                        prim_err = ERR_WIDTH;
                    end else begin
                        n_col   = '0;
                        n_ch    = '0;
                        n_run   = '0;
                        n_phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    if (r_byte > RUN_BIAS) begin
                        if (run_sum > w_ext) begin
                            prim_err = ERR_RUN_OVR;
                        end else begin
                            n_run   = BYTE_W'(r_byte[BYTE_W-2:0]);
                            n_phase = PH_RUNVAL;
                        end
                    end else if (r_byte == '0) begin
                        prim_err = ERR_ZERO_LIT;
                    end else if (lit_sum > w_ext) begin
                        prim_err = ERR_LIT_OVR;
                    end else begin
                        n_run   = r_byte;
                        n_phase = PH_LIT;
                    end
                end
                PH_RUNVAL, PH_LIT: begin
                    n_run = adv_run;
                    if (adv_col >= w_ext) begin
                        n_col = '0;
                        if (r_ch == CH_LAST) begin
                            n_ch    = '0;
                            n_row   = row_inc;
                            n_phase = end_phase;
                        end else begin
                            n_ch    = ch_inc;
                            n_phase = (adv_run != '0) ? PH_LIT : PH_CODE;
                        end
                    end else begin
                        n_col   = adv_col[REG_W-1:0];
                        n_phase = (adv_run != '0) ? PH_LIT : PH_CODE;
                    end
                end
                PH_FLAT: begin
                    n_ch    = ch_inc;
                    n_phase = PH_FLAT;
                    if (ch_inc == '0) begin
                        if (flat_col >= w_ext) begin
                            n_col   = '0;
                            n_row   = row_inc;
                            n_phase = end_phase;
                        end else begin
                            n_col = flat_col[REG_W-1:0];
                        end
                    end
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
            if (prim_err != ERR_NONE) begin
                n_err   = prim_err;
                n_phase = PH_HALT;
            end else if (r_fin && !(n_phase inside {PH_DONE, PH_HALT})) begin
                trunc   = 1'b1;
                n_err   = ERR_TRUNC;
                n_phase = PH_HALT;
            end
        end
    end

    // Destination row, saturated to the image and optionally flipped
    assign y_sat    = (r_row >= i_cfg.height) ? (i_cfg.height - REG_W'(1)) : r_row;
    assign dest_row = i_cfg.flip ? (i_cfg.height - REG_W'(1) - y_sat) : y_sat;
    assign has_stat = (prim_err != ERR_NONE) || trunc;

    // Outputs: assemble the results of this byte
    always_comb begin
        nw   = '0;
        wr0  = '0;
        wr1  = '0;
        stat = '0;

        wr0.is_write = 1'b1;
        wr0.row      = dest_row[ROW_W-1:0];
        wr0.column   = r_col[COL_W-1:0];
        wr0.channel  = r_ch;
        wr0.value    = r_byte;
        wr0.rep      = REP_W'(1);
        wr0.err      = ERR_NONE;

        wr1.is_write = 1'b1;
        wr1.row      = dest_row[ROW_W-1:0];
        wr1.column   = '0;
        wr1.channel  = CH_W'(1);
        wr1.value    = r_byte;
        wr1.rep      = REP_W'(1);
        wr1.err      = ERR_NONE;

        stat.err = (prim_err != ERR_NONE) ? prim_err : ERR_TRUNC;

        if (active) begin
            case (r_phase)
                PH_SECOND: begin
                    if (!(r_held == RLE_MARK && r_byte == RLE_MARK)) begin
                        nw          = CNT_W'(2);
                        wr0.column  = '0;
                        wr0.channel = '0;
                        wr0.value   = r_held;
                    end
                end
                PH_RUNVAL: begin
                    nw      = CNT_W'(1);
                    wr0.rep = r_run[REP_W-1:0];
                end
                PH_LIT, PH_FLAT: begin
                    nw = CNT_W'(1);
                end
                default: begin
                    nw = '0;
                end
            endcase
        end

        wr0.image_done = (nw == CNT_W'(1)) && (n_phase == PH_DONE);
        wr1.image_done = (n_phase == PH_DONE);

        o_batch.cnt = proc ? (nw + CNT_W'(has_stat)) : '0;
        o_batch.res[0] = (nw != '0)       ? wr0 : stat;
        o_batch.res[1] = (nw == CNT_W'(2)) ? wr1 : stat;
        o_batch.res[2] = stat;
        o_batch.res[0].last = (nw + CNT_W'(has_stat)) == CNT_W'(1);
        o_batch.res[1].last = (nw + CNT_W'(has_stat)) == CNT_W'(2);
        o_batch.res[2].last = 1'b1;
    end

    `RGBE_ASSERT_IMPL(a_halt_silent, i_clk, i_rst_n, (r_phase == PH_HALT) || (r_phase == PH_DONE), o_batch.cnt == '0)
    `RGBE_ASSERT_IMPL(a_err_halts, i_clk, i_rst_n, r_err != ERR_NONE, r_phase == PH_HALT)
    `RGBE_ASSERT_NEXT(a_status_stops, i_clk, i_rst_n, proc && has_stat, r_phase == PH_HALT)

endmodule

/* hdl/rgbe_rle_obuf.sv */
// Three-slot result buffer feeding the output channel one result per cycle unless stalled.
`include "rgbe_scanline_rle_decoder_top_defines.svh"
module rgbe_rle_obuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rgbe_rle_pkg::t_batch  i_batch,
    output logic                  o_load_ok,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rgbe_rle_pkg::t_result o_res
);
    import rgbe_rle_pkg::*;

    t_result          r_slot [NRES];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             pop;
    logic             load;

    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && !i_out_stall;
    // Take a new batch when the buffer is empty or its last held result leaves in this cycle
    assign o_load_ok   = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && pop);
    assign load        = o_load_ok && (i_batch.cnt != '0);
    assign o_res       = r_slot[0];

    always_comb begin
        n_cnt = r_cnt;
        if (pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
        if (load) begin
            n_cnt = i_batch.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot[0] <= i_batch.res[0];
            r_slot[1] <= i_batch.res[1];
            r_slot[2] <= i_batch.res[2];
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    `RGBE_ASSERT_IMPL(a_last_at_tail, i_clk, i_rst_n, r_cnt == CNT_W'(1), r_slot[0].last)
    `RGBE_ASSERT_IMPL(a_no_early_last, i_clk, i_rst_n, r_cnt > CNT_W'(1), !r_slot[0].last)

endmodule

/* hdl/rgbe_scanline_rle_decoder_top.sv */
// Top level of the Radiance RGBE scanline run-length decoder.
// Takes the pixel-data bytes of an RGBE image (everything after the resolution line) one
// request per cycle and turns them into scanline writes: destination row (flipped when
// flip_rows is set), first column, channel (0 R, 1 G, 2 B, 3 E), value and a repeat
// count, so a run leaves as a single write. A scanline that opens with 02 02 and the
// big-endian width is decoded as run-length channels; any other opening is flat RGBE,
// forwarded one byte per write. Decode faults (width mismatch, run overrun, zero literal,
// literal overrun, and truncation when final_byte arrives before the image is complete)
// are reported once as a status result with is_write low, after which the block drops
// every byte until reset; bytes after the last scanline are dropped silently. Every byte
// is registered in the input register, decoded combinationally and its results loaded
// into a three-slot output buffer whose first slot drives the result channel. A byte that
// causes at most one result is accepted every cycle while the output is not stalled; the
// opening of a flat scanline causes two (three with truncation), and the input stalls
// while the output buffer hands them out, one per cycle unless stalled. Configure scan_width
// (0x0), image_height (0x4) and flip_rows (0x8) while no request is in flight;
// width and height are clamped to 1..MAX_DIMENSION.
module rgbe_scanline_rle_decoder_top #(
    parameter int MAX_DIMENSION = rgbe_rle_pkg::DIM_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgbe_rle_pkg::PADDR_W-1:0] paddr,
    input  logic [rgbe_rle_pkg::PDATA_W-1:0] pwdata,
    output logic [rgbe_rle_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    // byte input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [rgbe_rle_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                             i_final_byte,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_is_write,
    output logic [rgbe_rle_pkg::ROW_W-1:0]   o_out_row,
    output logic [rgbe_rle_pkg::COL_W-1:0]   o_out_column,
    output logic [rgbe_rle_pkg::CH_W-1:0]    o_out_channel,
    output logic [rgbe_rle_pkg::BYTE_W-1:0]  o_out_value,
    output logic [rgbe_rle_pkg::REP_W-1:0]   o_repeat_res,
    output logic [rgbe_rle_pkg::ERR_W-1:0]   o_error_code,
    output logic                             o_image_done,
    output logic                             o_last
);
    import rgbe_rle_pkg::*;

    t_cfg    cfg;
    t_batch  batch;
    t_result res;
    logic    load_ok;

    // Registers: clamped geometry is computed on the write, not per byte
    rgbe_rle_cfg #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Decode one byte per cycle; hold the byte while the buffer is still busy
    rgbe_rle_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_load_ok    (load_ok),
        .o_batch      (batch)
    );

    // Buffer the results of each byte and hand them to the output in delivery order
    rgbe_rle_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_batch     (batch),
        .o_load_ok   (load_ok),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_is_write    = res.is_write;
    assign o_out_row     = res.row;
    assign o_out_column  = res.column;
    assign o_out_channel = res.channel;
    assign o_out_value   = res.value;
    assign o_repeat_res  = res.rep;
    assign o_error_code  = res.err;
    assign o_image_done  = res.image_done;
    assign o_last        = res.last;

endmodule
